>>> src/brq_pkg.sv
package brq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_W     = 2;
    localparam int CONN_W   = 16;
    localparam int TIME_W   = 48;
    localparam int LEVEL_W  = 7;
    localparam int RND_W    = 16;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = CONN_W + TIME_W;
    localparam int SUM_W    = ((CNT_W > LEVEL_W) ? CNT_W : LEVEL_W) + 1;
    localparam int STEP_W   = $clog2(RND_W);

    localparam logic [LEVEL_W-1:0] LIMIT_RESET = LEVEL_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 2'd0,
        OP_TAKE      = 2'd1,
        OP_DROP_OLD  = 2'd2,
        OP_DROP_RAND = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_READ,
        S_CAPT,
        S_SHIFT,
        S_DONE
    } t_state;

    // circular step back by a distance smaller than the depth
    function automatic logic [DEPTH_W-1:0] slot_back(input logic [DEPTH_W-1:0] from,
                                                    input logic [DEPTH_W-1:0] back);
        logic [DEPTH_W:0] diff;
        diff = {1'b0, from} - {1'b0, back};
        if (from < back) begin
            diff = diff + (DEPTH_W+1)'(QUEUE_DEPTH);
        end
        return diff[DEPTH_W-1:0];
    endfunction

    function automatic logic [DEPTH_W-1:0] slot_next(input logic [DEPTH_W-1:0] from);
        logic [DEPTH_W-1:0] nxt;
        if (from == DEPTH_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = from + DEPTH_W'(1);
        end
        return nxt;
    endfunction

endpackage

>>> src/bounded_request_queue_with_drop_core.sv
// channel | direction | handshake                 | payload
// request | in        | i_valid / o_stall         | i_operation .. i_random_word
// result  | out       | o_valid / i_stall         | o_status .. o_occupancy
// config  | in        | i_cfg_we, no back-pressure| i_cfg_data (queue limit)
//
// add or refused op: straight to the finish state, which loads the result register
// take / drop oldest: read, capture, finish; one memory read of the oldest slot
// drop random: remainder unit, then read, capture, k entries moved at one per cycle
// one request in flight; a new request is taken while the last result still waits
// reset (sync, active low): count, pointer cleared, limit 64, entry memory not cleared
// a stalled result holds and blocks only the finish of the next request
module bounded_request_queue_with_drop_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [brq_pkg::LEVEL_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [brq_pkg::OP_W-1:0]     i_operation,
    input  logic [brq_pkg::CONN_W-1:0]   i_connection,
    input  logic [brq_pkg::TIME_W-1:0]   i_arrival_us,
    input  logic [brq_pkg::TIME_W-1:0]   i_now_us,
    input  logic [brq_pkg::LEVEL_W-1:0]  i_busy_count,
    input  logic [brq_pkg::RND_W-1:0]    i_random_word,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [brq_pkg::STATUS_W-1:0] o_status,
    output logic [brq_pkg::CONN_W-1:0]   o_out_connection,
    output logic [brq_pkg::TIME_W-1:0]   o_out_arrival_us,
    output logic [brq_pkg::TIME_W-1:0]   o_dispatch_us,
    output logic [brq_pkg::LEVEL_W-1:0]  o_occupancy
);

    import brq_pkg::*;

    t_state               r_state;
    t_state               n_state;
    t_op                  r_op;
    t_op                  in_op;
    logic [CNT_W-1:0]     r_count;
    logic [DEPTH_W-1:0]   r_newest;
    logic [LEVEL_W-1:0]   r_limit;
    logic [DEPTH_W-1:0]   r_pos;
    logic [DEPTH_W-1:0]   r_back;
    t_status              r_status;
    logic [CONN_W-1:0]    r_conn;
    logic [TIME_W-1:0]    r_arr;
    logic [TIME_W-1:0]    r_disp;

    logic                 r_o_valid;
    t_status              r_o_status;
    logic [CONN_W-1:0]    r_o_conn;
    logic [TIME_W-1:0]    r_o_arr;
    logic [TIME_W-1:0]    r_o_disp;
    logic [LEVEL_W-1:0]   r_o_occ;

    logic                 in_accept;
    logic                 is_full;
    logic                 is_empty;
    logic [SUM_W-1:0]     level_sum;

    logic                 ram_we;
    logic [DEPTH_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [DEPTH_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 mod_start;
    logic                 mod_done;
    logic [DEPTH_W-1:0]   mod_rem;
    logic                 load_out;
    logic                 finish_rm;

    assign in_op     = t_op'(i_operation);
    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign level_sum = SUM_W'(r_count) + SUM_W'(i_busy_count);
    assign is_full   = (r_count >= CNT_W'(QUEUE_DEPTH)) || (level_sum >= SUM_W'(r_limit));
    assign is_empty  = (r_count == '0);

    // removal done when the last move (or the capture, if none) completes
    assign finish_rm = ((r_state == S_CAPT) && (r_back == '0)) ||
                       ((r_state == S_SHIFT) && (r_back == DEPTH_W'(1)));

    brq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    brq_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_random_word),
        .i_divisor  (r_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (in_op == OP_ADD || is_empty) begin
                        n_state = S_DONE;
                    end else if (in_op == OP_DROP_RAND) begin
                        n_state = S_MOD;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_CAPT;
            S_CAPT: begin
                n_state = (r_back == '0) ? S_DONE : S_SHIFT;
            end
            S_SHIFT: begin
                if (r_back == DEPTH_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_pos;
        mod_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept && in_op == OP_ADD && !is_full) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_next(r_newest);
                    ram_wdata = {i_connection, i_arrival_us};
                end
                mod_start = in_accept && (in_op == OP_DROP_RAND) && !is_empty;
            end
            S_READ: begin
                ram_re = 1'b1;
            end
            S_CAPT: begin
                // prefetch the entry just newer than the removed one
                if (r_back != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_next(r_pos);
                end
            end
            S_SHIFT: begin
                ram_we = 1'b1;
                if (r_back != DEPTH_W'(1)) begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_next(slot_next(r_pos));
                end
            end
            S_DONE: begin
                load_out = !r_o_valid || !i_stall;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_newest <= '0;
            r_limit  <= LIMIT_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (in_accept) begin
                if (in_op == OP_ADD) begin
                    if (!is_full) begin
                        r_newest <= slot_next(r_newest);
                        r_count  <= r_count + CNT_W'(1);
                    end
                end else if (!is_empty) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
            if (finish_rm && r_op == OP_DROP_RAND) begin
                r_newest <= slot_back(r_newest, DEPTH_W'(1));
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= in_op;
            r_conn <= '0;
            r_arr  <= '0;
            r_disp <= (in_op == OP_TAKE && !is_empty) ? i_now_us : '0;
            r_back <= '0;
            // oldest sits count-1 slots behind the newest
            r_pos  <= slot_back(r_newest, DEPTH_W'(r_count - CNT_W'(1)));
            if (in_op == OP_ADD) begin
                r_status <= is_full ? STS_FULL : STS_DONE;
            end else begin
                r_status <= is_empty ? STS_EMPTY : STS_DONE;
            end
        end
        if (r_state == S_MOD && mod_done) begin
            r_pos  <= slot_back(r_newest, mod_rem);
            r_back <= mod_rem;
        end
        if (r_state == S_CAPT) begin
            r_conn <= ram_rdata[ENTRY_W-1 -: CONN_W];
            r_arr  <= ram_rdata[TIME_W-1:0];
        end
        if (r_state == S_SHIFT) begin
            r_pos  <= slot_next(r_pos);
            r_back <= r_back - DEPTH_W'(1);
        end
        if (load_out) begin
            r_o_status <= r_status;
            r_o_conn   <= r_conn;
            r_o_arr    <= r_arr;
            r_o_disp   <= r_disp;
            r_o_occ    <= LEVEL_W'(r_count);
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_out_connection = r_o_conn;
    assign o_out_arrival_us = r_o_arr;
    assign o_dispatch_us    = r_o_disp;
    assign o_occupancy      = r_o_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_MOD))
        else $error("remainder finished outside its wait state");

    a_ram_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write of one entry in the same cycle");

    a_refused_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_op == OP_ADD && is_full) |=> $stable(r_count) && $stable(r_newest))
        else $error("refused add changed the queue");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the finish state");

endmodule

>>> src/brq_ram.sv
module brq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/brq_mod.sv
module brq_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [brq_pkg::RND_W-1:0]   i_dividend,
    input  logic [brq_pkg::CNT_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [brq_pkg::DEPTH_W-1:0] o_rem
);

    import brq_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RND_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    n_rem;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        trial = {r_rem, r_dvd[RND_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = trial - {1'b0, r_dvs};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            r_rem <= n_rem[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[DEPTH_W-1:0];

endmodule
